// File: sv/ihb_pkg.sv
// Shared types, constants and the header word selector for the IPv4 header builder.
// No dependencies; used by ihb_sum, ihb_serial and ipv4_header_builder.
package ihb_pkg;

  // Fixed header contents.
  localparam logic [15:0] WORD_VER_IHL  = 16'h4500;
  localparam logic [15:0] WORD_IDENT    = 16'h0000;
  localparam logic [15:0] WORD_DONT_FRAG = 16'h4000;
  localparam logic [7:0]  TTL_MAX       = 8'hFF;
  localparam logic [16:0] HDR_BYTES     = 17'd20;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK   = 1'b1;

  // Header word positions.
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] W_VER      = 4'd0;
  localparam logic [IDX_W-1:0] W_LENGTH   = 4'd1;
  localparam logic [IDX_W-1:0] W_IDENT    = 4'd2;
  localparam logic [IDX_W-1:0] W_FRAG     = 4'd3;
  localparam logic [IDX_W-1:0] W_TTL      = 4'd4;
  localparam logic [IDX_W-1:0] W_CHECKSUM = 4'd5;
  localparam logic [IDX_W-1:0] W_SRC_HI   = 4'd6;
  localparam logic [IDX_W-1:0] W_SRC_LO   = 4'd7;
  localparam logic [IDX_W-1:0] W_DST_HI   = 4'd8;
  localparam logic [IDX_W-1:0] W_DST_LO   = 4'd9;

  // Everything needed to emit one header.
  typedef struct packed {
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [31:0] source;
    logic [31:0] target;
    logic [15:0] checksum;
    logic        broadcast;
    logic        length_error;
  } hdr_t;

  // Pick header word idx out of a finished header.
  function automatic logic [15:0] word_sel(hdr_t h, logic [IDX_W-1:0] idx);
    logic [15:0] w;
    w = 16'h0000;
    unique case (idx)
      W_VER:      w = WORD_VER_IHL;
      W_LENGTH:   w = h.total_length;
      W_IDENT:    w = WORD_IDENT;
      W_FRAG:     w = WORD_DONT_FRAG;
      W_TTL:      w = {TTL_MAX, h.protocol};
      W_CHECKSUM: w = h.checksum;
      W_SRC_HI:   w = h.source[31:16];
      W_SRC_LO:   w = h.source[15:0];
      W_DST_HI:   w = h.target[31:16];
      W_DST_LO:   w = h.target[15:0];
      default:    w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

// File: sv/ipv4_header_builder.sv
// Top level of the IPv4 header builder: configuration registers, checksum pipeline
// and word serialiser. Depends on ihb_pkg, ihb_sum and ihb_serial.
//
// Each accepted request (payload length, destination, protocol) produces the ten
// words of a 20-byte IPv4 header, one word per accepted output cycle, word 0 first.
// The output channel limits the sustained request rate. The first word of a request
// is valid after the three checksum stages and the serialiser load, and up to four
// requests can be held inside the block, so input is taken while earlier headers are
// still being sent. The source address and netmask are sampled when a request is
// accepted and should be written only while the block is idle. Writes to unknown
// register indexes are ignored.
module ipv4_header_builder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  payload_length,
  input  logic [31:0]                  target_address,
  input  logic [7:0]                   protocol_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  header_word,
  output logic                         last_word,
  output logic                         is_broadcast,
  output logic                         length_error,
  input  logic                         cfg_write,
  input  logic [ihb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  logic [31:0]   local_address;
  logic [31:0]   subnet_mask;
  logic          hdr_valid;
  logic          hdr_ready;
  ihb_pkg::hdr_t hdr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= 32'h0000_0000;
      subnet_mask   <= 32'h0000_0000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ihb_pkg::CFG_LOCAL_ADDRESS: local_address <= cfg_data;
        ihb_pkg::CFG_SUBNET_MASK:   subnet_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Checksum pipeline.
  ihb_sum u_sum (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .payload_length  (payload_length),
    .target_address  (target_address),
    .protocol_number (protocol_number),
    .local_address   (local_address),
    .subnet_mask     (subnet_mask),
    .hdr_valid       (hdr_valid),
    .hdr_ready       (hdr_ready),
    .hdr             (hdr)
  );

  // Word serialiser.
  ihb_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .hdr_valid    (hdr_valid),
    .hdr_ready    (hdr_ready),
    .hdr          (hdr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .header_word  (header_word),
    .last_word    (last_word),
    .is_broadcast (is_broadcast),
    .length_error (length_error)
  );

endmodule

// File: sv/ihb_sum.sv
// Three-stage checksum pipeline of the IPv4 header builder.
// Depends on ihb_pkg for hdr_t and the fixed header constants.
module ihb_sum (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        payload_length,
  input  logic [31:0]        target_address,
  input  logic [7:0]         protocol_number,
  input  logic [31:0]        local_address,
  input  logic [31:0]        subnet_mask,
  output logic               hdr_valid,
  input  logic               hdr_ready,
  output ihb_pkg::hdr_t      hdr
);

  logic          v1, v2, v3;
  ihb_pkg::hdr_t h1, h2, h3;
  logic [17:0]   sum_a1, sum_b1;
  logic [18:0]   sum2;

  logic          rdy1, rdy2, rdy3;
  logic [16:0]   full;
  logic [17:0]   sum_a, sum_b;
  logic [16:0]   fold1;
  logic [15:0]   fold2;
  ihb_pkg::hdr_t h1_next, h3_next;

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy3     = !v3 || hdr_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage one: total length, flags and two partial sums of the header words.
  assign full  = {1'b0, payload_length} + ihb_pkg::HDR_BYTES;
  assign sum_a = 18'(ihb_pkg::WORD_VER_IHL) + 18'(ihb_pkg::WORD_DONT_FRAG)
               + 18'({ihb_pkg::TTL_MAX, protocol_number}) + 18'(full[15:0])
               + 18'(ihb_pkg::WORD_IDENT);
  assign sum_b = 18'(local_address[31:16]) + 18'(local_address[15:0])
               + 18'(target_address[31:16]) + 18'(target_address[15:0]);

  always_comb begin
    h1_next.total_length = full[15:0];
    h1_next.protocol     = protocol_number;
    h1_next.source       = local_address;
    h1_next.target       = target_address;
    h1_next.checksum     = 16'h0000;
    h1_next.broadcast    = &(target_address | subnet_mask);
    h1_next.length_error = full[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      h1     <= h1_next;
      sum_a1 <= sum_a;
      sum_b1 <= sum_b;
    end
  end

  // Stage two: full sum of all header words.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      h2   <= h1;
      sum2 <= 19'(sum_a1) + 19'(sum_b1);
    end
  end

  // Stage three: two end-around folds and the complement.
  assign fold1 = 17'(sum2[15:0]) + 17'(sum2[18:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    h3_next          = h2;
    h3_next.checksum = ~fold2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      h3 <= h3_next;
    end
  end

  assign hdr_valid = v3;
  assign hdr       = h3;

endmodule

// File: sv/ihb_serial.sv
// Serialiser that emits one finished header as ten 16-bit words.
// Depends on ihb_pkg for hdr_t, the word positions and word_sel.
module ihb_serial (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      hdr_valid,
  output logic                      hdr_ready,
  input  ihb_pkg::hdr_t             hdr,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               header_word,
  output logic                      last_word,
  output logic                      is_broadcast,
  output logic                      length_error
);

  logic                      busy;
  logic [ihb_pkg::IDX_W-1:0] idx;
  ihb_pkg::hdr_t             cur;
  logic                      at_last;
  logic                      take;

  assign at_last   = (idx == ihb_pkg::W_DST_LO);
  // A new header loads when idle or as the final word leaves.
  assign hdr_ready = !busy || (out_ready && at_last);
  assign take      = hdr_ready && hdr_valid;

  // Word counter and the held header.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= ihb_pkg::W_VER;
    end else if (take) begin
      busy <= 1'b1;
      idx  <= ihb_pkg::W_VER;
    end else if (busy && out_ready) begin
      if (at_last) begin
        busy <= 1'b0;
        idx  <= ihb_pkg::W_VER;
      end else begin
        idx <= idx + 1'b1;
      end
    end
    if (take) begin
      cur <= hdr;
    end
  end

  assign out_valid    = busy;
  assign header_word  = ihb_pkg::word_sel(cur, idx);
  assign last_word    = at_last;
  assign is_broadcast = cur.broadcast;
  assign length_error = cur.length_error;

  // The counter never runs past the final word.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= ihb_pkg::W_DST_LO)
    else $error("word index beyond final word");

  // A taken word that is not the last advances the counter by one.
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && !at_last) |=> idx == $past(idx) + 1'b1)
    else $error("word index did not advance");

  // After the final word with nothing waiting, the serialiser goes idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && out_ready && at_last && !hdr_valid) |=> !busy)
    else $error("serialiser still busy after final word");

  // A new header always starts at the first word.
  a_load_first: assert property (@(posedge clk) disable iff (rst)
    take |=> (busy && idx == ihb_pkg::W_VER))
    else $error("new header did not start at word zero");

endmodule
